@@ hdl/box_blur_3x3_clipped_core_defines.svh @@
// ----------------------------------------------------------------------------
// Box blur 3x3 assertion macros
// Concurrent assertion shorthands clocked on clk and disabled during arst_n.
// ----------------------------------------------------------------------------
`ifndef BOX_BLUR_3X3_CLIPPED_CORE_DEFINES_SVH
`define BOX_BLUR_3X3_CLIPPED_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset
`define BBC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Expression must never be true outside reset
`define BBC_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define BBC_ASSERT(lbl, prop, msg)
`define BBC_NEVER(lbl, expr, msg)
`endif

`endif

@@ hdl/bbc_pkg.sv @@
// ----------------------------------------------------------------------------
// Box blur 3x3 package
// Widths, register codes, controller states, command/status bundles and the
// reciprocal table used for the clipped-window mean.
// ----------------------------------------------------------------------------
`default_nettype none

package bbc_pkg;

	// Pixel and image geometry
	localparam int PIX_W  = 8;
	localparam int MAX_W  = 1024;
	localparam int MAX_H  = 1024;
	localparam int DIM_W  = 11;
	localparam int COL_W  = $clog2(MAX_W);
	localparam int ROW_W  = $clog2(MAX_H);

	// Window sum and reciprocal divide
	localparam int SUM_W  = PIX_W + 4;
	localparam int CNT_W  = 4;
	localparam int RCP_SH = 16;
	localparam int RCP_W  = RCP_SH + 1;
	localparam int PROD_W = SUM_W + RCP_W;

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'd1;

	localparam logic [DIM_W-1:0] MAX_W_DIM = DIM_W'(MAX_W);
	localparam logic [DIM_W-1:0] MAX_H_DIM = DIM_W'(MAX_H);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_SUM,
		ST_MULT,
		ST_OUT
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic accept;
		logic cfg_wr;
		logic shift;
		logic sum;
		logic mult;
		logic load;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic emit;
		logic out_free;
	} sts_t;

	// Which window borders lie inside the image
	typedef struct packed {
		logic top;
		logic bot;
		logic left;
		logic right;
	} border_t;

	// Saturate a register value into 1..maxv
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
		input logic [DIM_W-1:0] maxv);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > maxv) begin
			r = maxv;
		end else begin
			r = v;
		end
		return r;
	endfunction

	// ceil(2^RCP_SH / n), exact for every sum up to 255*n
	function automatic logic [RCP_W-1:0] recip(input logic [CNT_W-1:0] n);
		logic [RCP_W-1:0] r;
		case (n)
			CNT_W'(1): r = RCP_W'(65536);
			CNT_W'(2): r = RCP_W'(32768);
			CNT_W'(3): r = RCP_W'(21846);
			CNT_W'(4): r = RCP_W'(16384);
			CNT_W'(6): r = RCP_W'(10923);
			CNT_W'(9): r = RCP_W'(7282);
			default:   r = RCP_W'(65536);
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

@@ hdl/bbc_ctrl.sv @@
// ----------------------------------------------------------------------------
// Box blur 3x3 controller
// Sequences one item at a time: accept, shift window and write line stores, and,
// for a result, sum the clipped window, divide, then load the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "box_blur_3x3_clipped_core_defines.svh"

module bbc_ctrl import bbc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire logic cfg_valid,
	input  wire sts_t sts,
	output cmd_t      cmd,
	output logic      in_ready,
	output logic      cfg_ready
);

	state_t state_q;
	state_t state_nx;

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && !cfg_valid) begin
					state_nx = ST_SHIFT;
				end
			end
			ST_SHIFT: begin
				state_nx = sts.emit ? ST_SUM : ST_IDLE;
			end
			ST_SUM: begin
				state_nx = ST_MULT;
			end
			ST_MULT: begin
				state_nx = ST_OUT;
			end
			ST_OUT: begin
				if (sts.out_free) begin
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// Outputs: config has priority over a pixel beat in idle
	always_comb begin
		cfg_ready  = (state_q == ST_IDLE);
		in_ready   = (state_q == ST_IDLE) && !cfg_valid;
		cmd        = '0;
		cmd.cfg_wr = cfg_valid && cfg_ready;
		cmd.accept = in_valid && in_ready;
		cmd.shift  = (state_q == ST_SHIFT);
		cmd.sum    = (state_q == ST_SUM);
		cmd.mult   = (state_q == ST_MULT);
		cmd.load   = (state_q == ST_OUT) && sts.out_free;
	end

	`BBC_ASSERT(a_load_free, cmd.load |-> sts.out_free, "result loaded into busy output")
	`BBC_NEVER(a_cfg_vs_pix, cmd.accept && cmd.cfg_wr, "config write during pixel beat")
	`BBC_ASSERT(a_sum_after_shift, (state_q == ST_SUM) |-> ($past(state_q) == ST_SHIFT),
		"sum state not entered from shift")

endmodule

`default_nettype wire

@@ hdl/bbc_datapath.sv @@
// ----------------------------------------------------------------------------
// Box blur 3x3 datapath
// Position counters, two line stores, 3x3 window, clipped sum, reciprocal
// divide and the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "box_blur_3x3_clipped_core_defines.svh"

module bbc_datapath import bbc_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire cmd_t                 cmd,
	output sts_t                      sts,
	input  wire logic [PIX_W-1:0]     pixel_in,
	input  wire logic                 flush,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [DIM_W-1:0]     cfg_data,
	input  wire logic                 out_ready,
	output logic                      out_valid,
	output logic [PIX_W-1:0]          pixel_out,
	output logic                      last
);

	// Configuration and position state
	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic [DIM_W-1:0] in_row_q;
	logic [COL_W-1:0] in_col_q;
	logic [ROW_W-1:0] out_row_q;
	logic [COL_W-1:0] out_col_q;

	// Per-item context captured at accept
	logic             emit_q;
	logic             last_item_q;
	border_t          border_q;
	logic [PIX_W-1:0] pix_q;
	logic [COL_W-1:0] col_q;

	// Line stores and their registered read data
	logic [PIX_W-1:0] line_a [MAX_W];
	logic [PIX_W-1:0] line_b [MAX_W];
	logic [PIX_W-1:0] rd_a_q;
	logic [PIX_W-1:0] rd_b_q;

	logic [PIX_W-1:0] win_q [3][3];

	logic [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [PROD_W-1:0] prod_q;

	logic             out_valid_q;
	logic [PIX_W-1:0] pixel_out_q;
	logic             last_q;

	// Decode the current position
	logic             emit_now;
	logic             last_now;
	border_t          border_now;
	logic [DIM_W-1:0] in_col_inc;
	logic [DIM_W-1:0] out_col_inc;
	logic [DIM_W-1:0] out_row_inc;

	always_comb begin
		in_col_inc  = DIM_W'(in_col_q) + DIM_W'(1);
		out_col_inc = DIM_W'(out_col_q) + DIM_W'(1);
		out_row_inc = DIM_W'(out_row_q) + DIM_W'(1);
		emit_now    = (in_row_q >= DIM_W'(2)) ||
		              ((in_row_q == DIM_W'(1)) && (in_col_q != '0));
		last_now    = (out_row_inc >= height_q) && (out_col_inc >= width_q);
		border_now.top   = (out_row_q != '0);
		border_now.bot   = (out_row_inc < height_q);
		border_now.left  = (out_col_q != '0);
		border_now.right = (out_col_inc < width_q);
	end

	// Config registers and position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= MAX_W_DIM;
			height_q  <= MAX_H_DIM;
			in_row_q  <= '0;
			in_col_q  <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
		end else if (cmd.cfg_wr) begin
			case (cfg_index)
				REG_WIDTH:  width_q  <= clamp_dim(cfg_data, MAX_W_DIM);
				REG_HEIGHT: height_q <= clamp_dim(cfg_data, MAX_H_DIM);
				default: ;
			endcase
			in_row_q  <= '0;
			in_col_q  <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
		end else if (cmd.accept) begin
			if (emit_now && last_now) begin
				// Frame done: restart every counter
				in_row_q  <= '0;
				in_col_q  <= '0;
				out_row_q <= '0;
				out_col_q <= '0;
			end else begin
				if (emit_now) begin
					if (out_col_inc >= width_q) begin
						out_col_q <= '0;
						out_row_q <= out_row_inc[ROW_W-1:0];
					end else begin
						out_col_q <= out_col_inc[COL_W-1:0];
					end
				end
				if (in_col_inc >= width_q) begin
					in_col_q <= '0;
					if (in_row_q != '1) begin
						in_row_q <= in_row_q + DIM_W'(1);
					end
				end else begin
					in_col_q <= in_col_inc[COL_W-1:0];
				end
			end
		end
	end

	// Capture item context
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_q <= 1'b0;
		end else if (cmd.accept) begin
			emit_q <= emit_now;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			last_item_q <= last_now;
			border_q    <= border_now;
			pix_q       <= flush ? '0 : pixel_in;
			col_q       <= in_col_q;
		end
	end

	// Line stores: read on accept, write back on shift.
	// Reset contents are never summed, so the stores are not cleared.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			rd_a_q <= line_a[in_col_q];
			rd_b_q <= line_b[in_col_q];
		end
		if (cmd.shift) begin
			line_a[col_q] <= pix_q;
			line_b[col_q] <= rd_a_q;
		end
	end

	// Advance the window one column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					win_q[r][c] <= '0;
				end
			end
		end else if (cmd.shift) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
			end
			win_q[0][2] <= rd_b_q;
			win_q[1][2] <= rd_a_q;
			win_q[2][2] <= pix_q;
		end
	end

	// Sum the in-image neighbors and count them
	logic [2:0]       row_ok;
	logic [2:0]       col_ok;
	logic [SUM_W-1:0] sum_now;
	logic [1:0]       n_rows;
	logic [1:0]       n_cols;

	always_comb begin
		row_ok  = {border_q.bot, 1'b1, border_q.top};
		col_ok  = {border_q.right, 1'b1, border_q.left};
		sum_now = '0;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				if (row_ok[r] && col_ok[c]) begin
					sum_now = sum_now + SUM_W'(win_q[r][c]);
				end
			end
		end
		n_rows = 2'd1 + 2'(border_q.top) + 2'(border_q.bot);
		n_cols = 2'd1 + 2'(border_q.left) + 2'(border_q.right);
	end

	// Sum, then divide by multiplying with the reciprocal
	always_ff @(posedge clk) begin
		if (cmd.sum) begin
			sum_q <= sum_now;
			cnt_q <= CNT_W'(n_rows) * CNT_W'(n_cols);
		end
		if (cmd.mult) begin
			prod_q <= PROD_W'(sum_q) * PROD_W'(recip(cnt_q));
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pixel_out_q <= prod_q[RCP_SH +: PIX_W];
			last_q      <= last_item_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign pixel_out    = pixel_out_q;
	assign last         = last_q;
	assign sts.emit     = emit_q;
	assign sts.out_free = !out_valid_q || out_ready;

	`BBC_ASSERT(a_in_col_range, DIM_W'(in_col_q) < width_q, "input column beyond width")
	`BBC_ASSERT(a_out_col_range, DIM_W'(out_col_q) < width_q, "output column beyond width")
	`BBC_ASSERT(a_frame_restart, (cmd.accept && emit_now && last_now) |=>
		((in_row_q == '0) && (in_col_q == '0) && (out_row_q == '0) && (out_col_q == '0)),
		"counters not cleared after frame end")

endmodule

`default_nettype wire

@@ hdl/box_blur_3x3_clipped_core.sv @@
// ----------------------------------------------------------------------------
// Box blur 3x3 clipped core
// Raster-order 3x3 mean filter; the window is clipped to the image so the
// divisor is the count of in-image neighbors.
// ----------------------------------------------------------------------------
//  channel | signals                               | dir
//  --------+---------------------------------------+-----
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data| in
//  in      | in_valid in_ready pixel_in flush      | in
//  out     | out_valid out_ready pixel_out last    | out
//
// An item that yields no result goes through accept and window shift; one that
// yields a result then also goes through sum, reciprocal multiply and output
// load, in a controller sequence around the registered line-store read.
// The output register holds one result, so the next item is accepted while it
// waits; the load stage stalls only if the previous result is still untaken.
// Reset restores 1024x1024 and clears the counters; line stores are not swept.
// ----------------------------------------------------------------------------
`default_nettype none

module box_blur_3x3_clipped_core import bbc_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [DIM_W-1:0]     cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [PIX_W-1:0]     pixel_in,
	input  wire logic                 flush,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [PIX_W-1:0]          pixel_out,
	output logic                      last
);

	cmd_t cmd;
	sts_t sts;

	bbc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.cfg_valid (cfg_valid),
		.sts       (sts),
		.cmd       (cmd),
		.in_ready  (in_ready),
		.cfg_ready (cfg_ready)
	);

	bbc_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.pixel_in  (pixel_in),
		.flush     (flush),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.pixel_out (pixel_out),
		.last      (last)
	);

endmodule

`default_nettype wire

@@ bench/box_blur_3x3_clipped_core_tb.sv @@
// ----------------------------------------------------------------------------
// Box blur 3x3 clipped core testbench
// Streams raster frames through the core under random source and sink gaps,
// predicts each blurred pixel with a behavioral copy of the clipped 3x3 mean
// and compares every output beat against the oldest prediction in order.
// ----------------------------------------------------------------------------

module box_blur_3x3_clipped_core_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import bbc_pkg::*;

	// Cycles the core may still be busy after the last result has left
	localparam int DRAIN_CYCLES = 8;
	// Cycles without any accepted beat before the run is declared hung
	localparam int STALL_LIMIT  = 3000;

	typedef struct {
		logic [PIX_W-1:0] pixel;
		logic             last;
	} blur_result_t;

	logic                 clk;
	logic                 arst_n     = 1'b0;
	logic                 cfg_valid  = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index  = REG_WIDTH;
	logic [DIM_W-1:0]     cfg_data   = '0;
	logic                 in_valid   = 1'b0;
	logic                 in_ready;
	logic [PIX_W-1:0]     pixel_in   = '0;
	logic                 flush      = 1'b0;
	logic                 out_valid;
	logic                 out_ready  = 1'b0;
	logic [PIX_W-1:0]     pixel_out;
	logic                 last;

	// Behavioral image state
	logic [PIX_W-1:0] row_above  [MAX_W];
	logic [PIX_W-1:0] row_above2 [MAX_W];
	logic [PIX_W-1:0] nbhd [3][3];
	int unsigned      cur_width, cur_height;
	int unsigned      src_row, src_col, dst_row, dst_col;

	blur_result_t expected_blur[$];
	int           src_idle_pct = 0;
	int           snk_idle_pct = 0;
	int unsigned  items_sent   = 0;
	int           error_count  = 0;
	int           stall_cycles = 0;

	box_blur_3x3_clipped_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.pixel_in  (pixel_in),
		.flush     (flush),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pixel_out (pixel_out),
		.last      (last)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Zero maps to one, anything past the maximum saturates
	function automatic int unsigned fit_dim(input logic [DIM_W-1:0] v, input int unsigned maxv);
		if (v == '0)
			return 1;
		if (v > maxv)
			return maxv;
		return v;
	endfunction

	// Advance the image state by one accepted beat and queue the pixel it yields
	task automatic predict_blur(input logic [PIX_W-1:0] p, input logic f);
		logic [PIX_W-1:0] v, upper, middle;
		int               r, c, r_lo, r_hi, c_lo, c_hi;
		int unsigned      total, taps;
		blur_result_t     res;
		v      = f ? '0 : p;
		upper  = row_above2[src_col];
		middle = row_above[src_col];
		row_above2[src_col] = middle;
		row_above[src_col]  = v;
		for (r = 0; r < 3; r++) begin
			nbhd[r][0] = nbhd[r][1];
			nbhd[r][1] = nbhd[r][2];
		end
		nbhd[0][2] = upper;
		nbhd[1][2] = middle;
		nbhd[2][2] = v;

		if (src_row >= 2 || (src_row == 1 && src_col >= 1)) begin
			// Clip the window to the rows and columns inside the image
			r_lo  = (dst_row > 0) ? 0 : 1;
			r_hi  = (dst_row + 1 < cur_height) ? 2 : 1;
			c_lo  = (dst_col > 0) ? 0 : 1;
			c_hi  = (dst_col + 1 < cur_width) ? 2 : 1;
			total = 0;
			taps  = 0;
			for (r = r_lo; r <= r_hi; r++) begin
				for (c = c_lo; c <= c_hi; c++) begin
					total += nbhd[r][c];
					taps++;
				end
			end
			res.pixel = PIX_W'(total / taps);
			res.last  = (dst_row + 1 >= cur_height) && (dst_col + 1 >= cur_width);
			expected_blur.push_back(res);
			// Frame end restarts every position counter
			if (res.last) begin
				src_row = 0;
				src_col = 0;
				dst_row = 0;
				dst_col = 0;
				return;
			end
			dst_col++;
			if (dst_col >= cur_width) begin
				dst_col = 0;
				dst_row++;
			end
		end

		src_col++;
		if (src_col >= cur_width) begin
			src_col = 0;
			if (src_row < 2047)
				src_row++;
		end
	endtask

	// Write width then height back to back; each write restarts the frame
	task automatic write_geometry(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
		cfg_valid <= 1'b1;
		cfg_index <= REG_WIDTH;
		cfg_data  <= w;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cur_width = fit_dim(w, MAX_W);
		cfg_index <= REG_HEIGHT;
		cfg_data  <= h;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cur_height = fit_dim(h, MAX_H);
		src_row = 0;
		src_col = 0;
		dst_row = 0;
		dst_col = 0;
		cfg_valid <= 1'b0;
	endtask

	// Send one input beat, with an optional random gap ahead of it
	task automatic send_pixel(input logic [PIX_W-1:0] p, input logic f);
		if ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < src_idle_pct)
				@(posedge clk);
		end
		in_valid <= 1'b1;
		pixel_in <= p;
		flush    <= f;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_blur(p, f);
		items_sent++;
	endtask

	// Drop valid, wait for every queued result, then let the pipeline empty
	task automatic settle_block();
		in_valid <= 1'b0;
		while (expected_blur.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Corners, edges, one-pixel images, flush inside the frame, pixel in padding
	task automatic test_directed_cases();
		settle_block();
		write_geometry(DIM_W'(3), DIM_W'(3));
		send_pixel(8'd255, 1'b0);
		send_pixel(8'd0, 1'b0);
		send_pixel(8'd255, 1'b0);
		send_pixel(8'd0, 1'b0);
		send_pixel(8'd255, 1'b1);	// flush inside the frame counts as zero
		send_pixel(8'd255, 1'b0);
		send_pixel(8'd255, 1'b0);
		send_pixel(8'd255, 1'b0);
		send_pixel(8'd0, 1'b0);
		send_pixel(8'd0, 1'b1);
		send_pixel(8'd200, 1'b0);	// plain pixel in the padding phase
		send_pixel(8'd17, 1'b1);
		send_pixel(8'd255, 1'b1);

		// Zero width is taken as one: a single-pixel image
		settle_block();
		write_geometry(DIM_W'(0), DIM_W'(1));
		send_pixel(8'd255, 1'b0);
		send_pixel(8'd0, 1'b1);
		send_pixel(8'd9, 1'b1);

		// One row of two: divisor two
		settle_block();
		write_geometry(DIM_W'(2), DIM_W'(0));
		send_pixel(8'd255, 1'b0);
		send_pixel(8'd254, 1'b0);
		send_pixel(8'd0, 1'b1);
		send_pixel(8'd0, 1'b1);
		send_pixel(8'd128, 1'b0);

		// One column of three: divisors two and three
		settle_block();
		write_geometry(DIM_W'(1), DIM_W'(3));
		send_pixel(8'd255, 1'b0);
		send_pixel(8'd1, 1'b0);
		send_pixel(8'd254, 1'b0);
		send_pixel(8'd0, 1'b1);
		send_pixel(8'd0, 1'b1);
	endtask

	// Oversized registers saturate to the maximum
	task automatic test_size_limits();
		int i;
		// Full-size frame: a short stretch of the first row yields nothing
		settle_block();
		write_geometry('1, '1);
		for (i = 0; i < 40; i++)
			send_pixel(PIX_W'($urandom_range(255)), 1'b0);

		// Tall single column: the bottom edge stays far away
		settle_block();
		write_geometry(DIM_W'(1), '1);
		for (i = 0; i < 24; i++)
			send_pixel(PIX_W'($urandom_range(255)), 1'b0);
	endtask

	// Random geometries and frames; some frames cut short, some odd padding
	task automatic test_random_frames(input int src_pct, input int snk_pct, input int quota);
		int unsigned first_item, w, h, npix, npad, i;
		int          frames, k;
		bit          cut;
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		first_item   = items_sent;
		while (items_sent - first_item < quota) begin
			w = ($urandom_range(7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
			h = ($urandom_range(7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
			settle_block();
			write_geometry(DIM_W'(w), DIM_W'(h));
			frames = $urandom_range(1, 3);
			for (k = 0; k < frames; k++) begin
				cut  = ($urandom_range(9) == 0);
				npix = cut ? $urandom_range(w * h - 1) : w * h;
				for (i = 0; i < npix; i++)
					send_pixel(PIX_W'($urandom_range(255)), $urandom_range(19) == 0);
				// Abandon the frame; the next register write restarts it
				if (cut)
					break;
				npad = ($urandom_range(9) == 0) ? $urandom_range(w + 3) : w + 1;
				for (i = 0; i < npad; i++)
					send_pixel(PIX_W'($urandom_range(255)), $urandom_range(3) != 0);
			end
		end
	endtask

	// Randomly stall the output side
	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= snk_idle_pct);

	// Compare each output beat with the oldest prediction
	always @(posedge clk) begin : check_out
		blur_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_blur.size() == 0) begin
				$error("pixel_out beat with nothing expected: actual %0d", pixel_out);
				error_count++;
			end else begin
				want = expected_blur.pop_front();
				if (pixel_out !== want.pixel) begin
					$error("pixel_out: expected %0d, actual %0d", want.pixel, pixel_out);
					error_count++;
				end
				if (last !== want.last) begin
					$error("last: expected %0d, actual %0d", want.last, last);
					error_count++;
				end
			end
		end
	end

	// End the run if no channel moves a beat for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		int i, r;
		for (i = 0; i < MAX_W; i++) begin
			row_above[i]  = '0;
			row_above2[i] = '0;
		end
		for (r = 0; r < 3; r++)
			for (i = 0; i < 3; i++)
				nbhd[r][i] = '0;
		cur_width  = MAX_W;
		cur_height = MAX_H;
		src_row    = 0;
		src_col    = 0;
		dst_row    = 0;
		dst_col    = 0;

		// Hold reset, then release on an edge
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle_pct = 25;
		snk_idle_pct = 88;
		test_directed_cases();
		test_size_limits();
		test_random_frames(25, 88, 300);
		test_random_frames(88, 25, 300);
		test_random_frames(0, 0, 300);

		settle_block();
		if (error_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
